@@ rtl/core/fpt_pkg.sv @@
// Shared types, constants and arithmetic helpers for the flame point transform.
package fpt_pkg;

    // Depth of the queue between the front and back pipelines.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Width of the configuration register index.
    localparam int CFG_INDEX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_PRE_X_AXIS  = 3'd1,
        REG_PRE_Y_AXIS  = 3'd2,
        REG_PRE_OFFSET  = 3'd3,
        REG_POST_X_AXIS = 3'd4,
        REG_POST_Y_AXIS = 3'd5,
        REG_POST_OFFSET = 3'd6
    } cfg_index_t;

    // A saturated 32-bit coordinate and its clamp flag.
    typedef struct packed {
        logic               clamp;
        logic signed [31:0] value;
    } sat_t;

    // One classified point handed from the front to the back.
    typedef struct packed {
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic [63:0]        r2;
        logic               mode;
        logic               flag;
        logic               degen;
    } entry_t;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic sat_t sat32(logic signed [65:0] v);
        sat_t r;
        r.clamp = 1'b0;
        r.value = v[31:0];
        if (v > 66'sd2147483647)
        begin
            r.clamp = 1'b1;
            r.value = 32'sh7FFFFFFF;
        end
        else if (v < -66'sd2147483648)
        begin
            r.clamp = 1'b1;
            r.value = 32'sh80000000;
        end
        return r;
    endfunction

    // One affine row: floor((p0 + p1) / 2^frac) + off, saturated.
    function automatic sat_t affine_row(logic signed [63:0] p0, logic signed [63:0] p1,
                                        logic signed [31:0] off, int unsigned frac);
        logic signed [65:0] sum;
        logic signed [65:0] sh;
        sum = 66'(p0) + 66'(p1);
        sh  = sum >>> frac;
        return sat32(sh + 66'(off));
    endfunction

endpackage

@@ rtl/core/fpt_if.sv @@
// Valid/ready channel interfaces for input points and transformed results.
interface fpt_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;

    modport source (output valid, output in_x, output in_y, input ready);
    modport sink (input valid, input in_x, input in_y, output ready);
endinterface

interface fpt_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               degenerate;
    logic               saturated;

    modport source (output valid, output out_x, output out_y, output degenerate,
                    output saturated, input ready);
    modport sink (input valid, input out_x, input out_y, input degenerate,
                  input saturated, output ready);
endinterface

@@ rtl/core/fpt_front.sv @@
// Front pipeline: pre affine map, squared radius and degenerate classification.
module fpt_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    fpt_point_if.sink       point,
    input  logic            mode,
    input  logic [63:0]     pre_x_axis,
    input  logic [63:0]     pre_y_axis,
    input  logic [63:0]     pre_offset,
    input  logic            full,
    output logic            push,
    output fpt_pkg::entry_t push_data
);
    import fpt_pkg::*;

    logic               advance;
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic signed [63:0] pxa_reg, pya_reg, pxb_reg, pyb_reg;
    logic signed [31:0] qx2_reg, qy2_reg, qx3_reg, qy3_reg;
    logic               flag2_reg, flag3_reg;
    logic [63:0]        sqx_reg, sqy_reg;
    entry_t             s4_reg;
    sat_t               row_x, row_y;
    logic [31:0]        mag_x, mag_y;
    logic [63:0]        r2;

    // The pipeline moves whenever its last stage can drain into the queue.
    assign advance     = !s4_valid_reg || !full;
    assign point.ready = advance;
    assign push        = s4_valid_reg && !full;
    assign push_data   = s4_reg;

    // Pre affine rows and magnitudes for the squares.
    always_comb
    begin
        row_x = affine_row(pxa_reg, pya_reg, pre_offset[31:0], FRAC_BITS);
        row_y = affine_row(pxb_reg, pyb_reg, pre_offset[63:32], FRAC_BITS);
        mag_x = qx2_reg[31] ? 32'(-qx2_reg) : 32'(qx2_reg);
        mag_y = qy2_reg[31] ? 32'(-qy2_reg) : 32'(qy2_reg);
        r2    = sqx_reg + sqy_reg;
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= point.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Stage payloads: products, pre map, squares, radius.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pxa_reg   <= point.in_x * $signed(pre_x_axis[31:0]);
            pya_reg   <= point.in_y * $signed(pre_y_axis[31:0]);
            pxb_reg   <= point.in_x * $signed(pre_x_axis[63:32]);
            pyb_reg   <= point.in_y * $signed(pre_y_axis[63:32]);
            qx2_reg   <= row_x.value;
            qy2_reg   <= row_y.value;
            flag2_reg <= row_x.clamp | row_y.clamp;
            qx3_reg   <= qx2_reg;
            qy3_reg   <= qy2_reg;
            flag3_reg <= flag2_reg;
            sqx_reg   <= mag_x * mag_x;
            sqy_reg   <= mag_y * mag_y;
            s4_reg.qx    <= qx3_reg;
            s4_reg.qy    <= qy3_reg;
            s4_reg.r2    <= r2;
            s4_reg.mode  <= mode;
            s4_reg.flag  <= flag3_reg;
            s4_reg.degen <= mode && (r2 == 64'd0);
        end
    end

endmodule

@@ rtl/core/fpt_queue.sv @@
// Small register queue between the front and back pipelines.
module fpt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fpt_pkg::entry_t push_data,
    input  logic            pop,
    output fpt_pkg::entry_t head,
    output logic            full,
    output logic            empty
);
    import fpt_pkg::*;

    entry_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;

    assign full  = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/fpt_back.sv @@
// Back pipeline: pipelined restoring dividers, post affine map and output register.
module fpt_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  fpt_pkg::entry_t head,
    input  logic            empty,
    output logic            pop,
    input  logic [63:0]     post_x_axis,
    input  logic [63:0]     post_y_axis,
    input  logic [63:0]     post_offset,
    fpt_result_if.source    result
);
    import fpt_pkg::*;

    localparam int STEPS = 32 + 2 * FRAC_BITS;

    // Partial state of one divider lane.
    typedef struct packed {
        logic [63:0] rem;
        logic [33:0] quo;
        logic        over;
        logic [31:0] mag;
        logic        neg;
    } lane_t;

    typedef struct packed {
        lane_t              lx;
        lane_t              ly;
        logic [63:0]        den;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic               mode;
        logic               flag;
        logic               degen;
    } dstage_t;

    // One restoring step: shift in a numerator bit, subtract when it fits.
    function automatic lane_t lane_step(lane_t l, logic b, logic [63:0] den);
        lane_t       r;
        logic [63:0] rem_sh;
        r      = l;
        rem_sh = {l.rem[62:0], b};
        r.quo  = l.over ? l.quo : {l.quo[32:0], 1'b0};
        r.rem  = rem_sh;
        if (rem_sh >= den)
        begin
            r.rem = rem_sh - den;
            if (!l.over)
            begin
                r.quo[0] = 1'b1;
            end
        end
        r.over = l.over | (r.quo > 34'h080000000);
        return r;
    endfunction

    // Step k of the division for both lanes.
    function automatic dstage_t stage_step(dstage_t s, int unsigned k);
        dstage_t r;
        logic    bx, by;
        r  = s;
        bx = 1'b0;
        by = 1'b0;
        if (k < 32)
        begin
            bx = s.lx.mag[5'(31 - k)];
            by = s.ly.mag[5'(31 - k)];
        end
        r.lx = lane_step(s.lx, bx, s.den);
        r.ly = lane_step(s.ly, by, s.den);
        return r;
    endfunction

    // Apply the sign and clamp the quotient.
    function automatic sat_t lane_finish(lane_t l);
        sat_t r;
        r.clamp = 1'b0;
        if (l.neg)
        begin
            if (l.over || l.quo > 34'h080000000)
            begin
                r.clamp = 1'b1;
                r.value = 32'sh80000000;
            end
            else
            begin
                r.value = 32'(-l.quo[31:0]);
            end
        end
        else
        begin
            if (l.over || l.quo > 34'h07FFFFFFF)
            begin
                r.clamp = 1'b1;
                r.value = 32'sh7FFFFFFF;
            end
            else
            begin
                r.value = l.quo[31:0];
            end
        end
        return r;
    endfunction

    logic               en;
    dstage_t            init;
    dstage_t            d_reg [STEPS];
    dstage_t            d_next [STEPS];
    logic [STEPS-1:0]   dv_reg;
    sat_t               fin_x, fin_y, row_x, row_y;
    logic               v5_reg, v6_reg, v7_reg;
    logic signed [31:0] ux5_reg, uy5_reg, qx5_reg, qy5_reg, qx6_reg, qy6_reg;
    logic               mode5_reg, degen5_reg, flag5_reg, mode6_reg, degen6_reg, flag6_reg;
    logic signed [63:0] pxa_reg, pya_reg, pxb_reg, pyb_reg;
    logic signed [31:0] out_x_reg, out_y_reg;
    logic               degen7_reg, sat7_reg;

    // The whole back pipeline advances when the output register is free.
    assign en  = !v7_reg || result.ready;
    assign pop = en && !empty;

    assign result.valid      = v7_reg;
    assign result.out_x      = out_x_reg;
    assign result.out_y      = out_y_reg;
    assign result.degenerate = degen7_reg;
    assign result.saturated  = sat7_reg;

    // Divider lane setup from the queue head and per-stage steps.
    always_comb
    begin
        init.lx.rem  = '0;
        init.lx.quo  = '0;
        init.lx.over = 1'b0;
        init.lx.neg  = head.qx[31];
        init.lx.mag  = head.qx[31] ? 32'(-head.qx) : 32'(head.qx);
        init.ly.rem  = '0;
        init.ly.quo  = '0;
        init.ly.over = 1'b0;
        init.ly.neg  = head.qy[31];
        init.ly.mag  = head.qy[31] ? 32'(-head.qy) : 32'(head.qy);
        init.den     = head.r2;
        init.qx      = head.qx;
        init.qy      = head.qy;
        init.mode    = head.mode;
        init.flag    = head.flag;
        init.degen   = head.degen;
        d_next[0] = stage_step(init, 0);
        for (int unsigned k = 1; k < STEPS; k++)
        begin
            d_next[k] = stage_step(d_reg[k-1], k);
        end
        fin_x = lane_finish(d_reg[STEPS-1].lx);
        fin_y = lane_finish(d_reg[STEPS-1].ly);
        row_x = affine_row(pxa_reg, pya_reg, post_offset[31:0], FRAC_BITS);
        row_y = affine_row(pxb_reg, pyb_reg, post_offset[63:32], FRAC_BITS);
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= '0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            dv_reg <= {dv_reg[STEPS-2:0], !empty};
            v5_reg <= dv_reg[STEPS-1];
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int unsigned k = 0; k < STEPS; k++)
            begin
                d_reg[k] <= d_next[k];
            end
            ux5_reg    <= fin_x.value;
            uy5_reg    <= fin_y.value;
            qx5_reg    <= d_reg[STEPS-1].qx;
            qy5_reg    <= d_reg[STEPS-1].qy;
            mode5_reg  <= d_reg[STEPS-1].mode;
            degen5_reg <= d_reg[STEPS-1].degen;
            flag5_reg  <= d_reg[STEPS-1].flag | (d_reg[STEPS-1].mode && !d_reg[STEPS-1].degen
                          && (fin_x.clamp || fin_y.clamp));
            pxa_reg    <= ux5_reg * $signed(post_x_axis[31:0]);
            pya_reg    <= uy5_reg * $signed(post_y_axis[31:0]);
            pxb_reg    <= ux5_reg * $signed(post_x_axis[63:32]);
            pyb_reg    <= uy5_reg * $signed(post_y_axis[63:32]);
            qx6_reg    <= qx5_reg;
            qy6_reg    <= qy5_reg;
            mode6_reg  <= mode5_reg;
            degen6_reg <= degen5_reg;
            flag6_reg  <= flag5_reg;
            // Final selection by mode and the zero-radius case.
            if (!mode6_reg)
            begin
                out_x_reg  <= qx6_reg;
                out_y_reg  <= qy6_reg;
                degen7_reg <= 1'b0;
                sat7_reg   <= flag6_reg;
            end
            else if (degen6_reg)
            begin
                out_x_reg  <= '0;
                out_y_reg  <= '0;
                degen7_reg <= 1'b1;
                sat7_reg   <= flag6_reg;
            end
            else
            begin
                out_x_reg  <= row_x.value;
                out_y_reg  <= row_y.value;
                degen7_reg <= 1'b0;
                sat7_reg   <= flag6_reg | row_x.clamp | row_y.clamp;
            end
        end
    end

endmodule

@@ rtl/core/flame_point_transform.sv @@
// Top level of the flame point transform: configuration registers and pipeline wiring.
//
// Each point in signed fixed point (FRAC_BITS fraction bits) goes through the pre
// affine map and, in spherical mode, is divided by its squared radius and passed
// through the post affine map. The block takes one point per cycle and delivers one
// result per cycle while the result side is ready; most of a point's pipeline depth
// comes from the pipelined restoring dividers, which spend one stage on each of
// their 32 + 2*FRAC_BITS quotient bits. A four-entry queue separates the front
// (pre map and radius) from the back (division, post map), so a stalled result
// holds only the back while the front keeps filling the queue. Registers must be
// written only while no point is in flight; the block itself does not enforce this.
module flame_point_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    fpt_point_if.sink                      point,
    fpt_result_if.source                   result,
    input  logic                           wr_en,
    input  logic [fpt_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [63:0]                    wr_data
);
    import fpt_pkg::*;

    localparam logic [63:0] ONE_X = 64'd1 << FRAC_BITS;
    localparam logic [63:0] ONE_Y = 64'd1 << (FRAC_BITS + 32);

    logic        mode_reg;
    logic [63:0] pre_x_axis_reg, pre_y_axis_reg, pre_offset_reg;
    logic [63:0] post_x_axis_reg, post_y_axis_reg, post_offset_reg;
    logic        q_push, q_pop, q_full, q_empty;
    entry_t      q_in, q_head;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            pre_x_axis_reg  <= ONE_X;
            pre_y_axis_reg  <= ONE_Y;
            pre_offset_reg  <= '0;
            post_x_axis_reg <= ONE_X;
            post_y_axis_reg <= ONE_Y;
            post_offset_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_MODE:        mode_reg        <= wr_data[0];
                REG_PRE_X_AXIS:  pre_x_axis_reg  <= wr_data;
                REG_PRE_Y_AXIS:  pre_y_axis_reg  <= wr_data;
                REG_PRE_OFFSET:  pre_offset_reg  <= wr_data;
                REG_POST_X_AXIS: post_x_axis_reg <= wr_data;
                REG_POST_Y_AXIS: post_y_axis_reg <= wr_data;
                REG_POST_OFFSET: post_offset_reg <= wr_data;
                default:         mode_reg        <= mode_reg;
            endcase
        end
    end

    // Front pipeline.
    fpt_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .point      (point),
        .mode       (mode_reg),
        .pre_x_axis (pre_x_axis_reg),
        .pre_y_axis (pre_y_axis_reg),
        .pre_offset (pre_offset_reg),
        .full       (q_full),
        .push       (q_push),
        .push_data  (q_in)
    );

    // Decoupling queue.
    fpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back pipeline.
    fpt_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .empty       (q_empty),
        .pop         (q_pop),
        .post_x_axis (post_x_axis_reg),
        .post_y_axis (post_y_axis_reg),
        .post_offset (post_offset_reg),
        .result      (result)
    );

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("queue push while full");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    // A zero-radius result carries a zero point.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.degenerate) |-> (result.out_x == 0 && result.out_y == 0))
        else $error("degenerate result with nonzero point");

endmodule
